>>> sv/emp_pkg.sv
// Shared types, codes and constants for the energy meter poll and decode block.
// Used by the front, queue, back and top-level modules; no dependencies.
package emp_pkg;

  // Query codes
  localparam logic [2:0] Q_VOLTAGE = 3'd0;
  localparam logic [2:0] Q_CURRENT = 3'd1;
  localparam logic [2:0] Q_POWER   = 3'd2;
  localparam logic [2:0] Q_ENERGY  = 3'd3;
  localparam logic [2:0] Q_NONE    = 3'd4;

  // Reply status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NO_QUERY = 2'd3;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_RX   = 1'b1;

  // Output kind codes
  localparam logic KIND_REQ   = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLED   = 3'd0;
  localparam logic [2:0] CFG_ADDRESS   = 3'd1;
  localparam logic [2:0] CFG_VOLT_LIM  = 3'd2;
  localparam logic [2:0] CFG_CURR_LIM  = 3'd3;
  localparam logic [2:0] CFG_POWER_LIM = 3'd4;

  // Frame header bases; the low two bits carry the query
  localparam logic [7:0] REQ_BASE  = 8'hB0;
  localparam logic [7:0] RESP_BASE = 8'hA0;

  localparam int POLL_CYCLE_DEF = 120;
  localparam int QUEUE_DEPTH    = 2;
  localparam int FRAME_BYTES    = 6;

  localparam logic [31:0] ADDR_RST      = 32'hC0A80101;
  localparam logic [19:0] VOLT_LIM_RST  = 20'd4000;
  localparam logic [22:0] CURR_LIM_RST  = 23'd10000;
  localparam logic [15:0] POWER_LIM_RST = 16'd25000;

  typedef struct packed {
    logic        enabled;
    logic [31:0] address;
    logic [19:0] volt_lim;
    logic [22:0] curr_lim;
    logic [15:0] power_lim;
  } emp_cfg_t;

  // One queued operation: a request to send, or a complete reply frame
  typedef struct packed {
    logic                        is_frame;
    logic [2:0]                  query;
    logic [FRAME_BYTES-1:0][7:0] frame;
    logic [7:0]                  sum_byte;
  } emp_op_t;

endpackage

>>> sv/emp_front.sv
// Front end: accepts input beats, runs the poll schedule and assembles reply frames.
// Depends on emp_pkg; pushes emp_op_t entries into the operation queue.
module emp_front #(
  parameter int POLL_CYCLE = emp_pkg::POLL_CYCLE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             enabled,
  input  logic             q_full,
  output logic             q_push,
  output emp_pkg::emp_op_t q_data
);
  import emp_pkg::*;

  localparam int STEP_W = $clog2(POLL_CYCLE + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POLL_CYCLE);
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);

  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [2:0]                  pend_r, pend_nxt;
  logic [2:0]                  idx_r, idx_nxt;
  logic [FRAME_BYTES-1:0][7:0] frame_r;
  logic                        accept;
  logic [2:0]                  pick;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (step_r == STEP_LAST) begin
      pick = Q_ENERGY;
    end else if (step_r[1:0] != 2'd0) begin
      pick = Q_CURRENT;
    end else if (step_r[2]) begin
      pick = Q_VOLTAGE;
    end else begin
      pick = Q_POWER;
    end
  end

  always_comb begin
    step_nxt = step_r;
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    q_push   = 1'b0;
    q_data   = '{is_frame: 1'b0, query: pick, frame: frame_r, sum_byte: in_tdata};
    if (accept) begin
      if (in_tuser == CMD_TICK) begin
        if (enabled && pend_r == Q_NONE) begin
          q_push   = 1'b1;
          pend_nxt = pick;
          step_nxt = (step_r == STEP_LAST) ? STEP_ONE : step_r + STEP_ONE;
        end
      end else if (idx_r < 3'(FRAME_BYTES)) begin
        idx_nxt = idx_r + 3'd1;
      end else begin
        q_push          = 1'b1;
        q_data.is_frame = 1'b1;
        q_data.query    = pend_r;
        pend_nxt        = Q_NONE;
        idx_nxt         = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_ONE;
      pend_r <= Q_NONE;
      idx_r  <= 3'd0;
    end else begin
      step_r <= step_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Frame bytes need no reset: all six are written before a frame is queued
  always_ff @(posedge clk) begin
    if (accept && in_tuser == CMD_RX && idx_r < 3'(FRAME_BYTES)) begin
      frame_r[idx_r] <= in_tdata;
    end
  end

endmodule

>>> sv/emp_queue.sv
// Short operation queue between the front end and the back end.
// Depends on emp_pkg for the entry type and depth.
module emp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  emp_pkg::emp_op_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output emp_pkg::emp_op_t head
);
  import emp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  emp_op_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

>>> sv/emp_back.sv
// Back end: sends request bytes, checks and decodes reply frames, keeps the readings.
// Depends on emp_pkg; drives the output register of the result channel.
module emp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  emp_pkg::emp_cfg_t cfg,
  input  logic              q_empty,
  input  emp_pkg::emp_op_t  q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import emp_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_REQ  = 2'd1;
  localparam logic [1:0] B_DEC  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  cnt_r;
  logic [2:0]  qry_r;
  logic [23:0] val_r;
  logic        bad_r;
  logic        out_free;

  logic        out_valid_r, out_kind_r, out_last_r;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_qty_r;
  logic [1:0]  out_status_r;
  logic [19:0] volt_r;
  logic [22:0] curr_r;
  logic [15:0] power_r;
  logic [23:0] energy_r;

  logic [7:0]  req_sum, req_byte, hdr_exp, rx_sum;
  logic [15:0] base;
  logic [23:0] val_dec;
  logic        bad_dec, in_range;
  logic [23:0] lim_sel;

  assign out_free = !out_valid_r || out_tready;

  // Request frame: code, four address bytes, zero byte, byte sum
  assign req_sum = (REQ_BASE | {6'd0, qry_r[1:0]}) + cfg.address[31:24]
                 + cfg.address[23:16] + cfg.address[15:8] + cfg.address[7:0];

  always_comb begin
    unique case (cnt_r)
      3'd0:    req_byte = REQ_BASE | {6'd0, qry_r[1:0]};
      3'd1:    req_byte = cfg.address[31:24];
      3'd2:    req_byte = cfg.address[23:16];
      3'd3:    req_byte = cfg.address[15:8];
      3'd4:    req_byte = cfg.address[7:0];
      3'd5:    req_byte = 8'd0;
      3'd6:    req_byte = req_sum;
      default: req_byte = 8'd0;
    endcase
  end

  // Reply decode, first step: header, sum and fixed-point value
  assign hdr_exp = RESP_BASE | {6'd0, q_head.query[1:0]};
  assign rx_sum  = q_head.frame[0] + q_head.frame[1] + q_head.frame[2]
                 + q_head.frame[3] + q_head.frame[4] + q_head.frame[5];
  assign bad_dec = (q_head.frame[0] != hdr_exp) || (rx_sum != q_head.sum_byte);
  assign base    = {q_head.frame[1], q_head.frame[2]};

  always_comb begin
    case (q_head.query)
      Q_VOLTAGE: val_dec = 24'(base * 20'd10) + {16'd0, q_head.frame[3]};
      Q_CURRENT: val_dec = 24'(base * 23'd100) + {16'd0, q_head.frame[3]};
      Q_POWER:   val_dec = {8'd0, base};
      default:   val_dec = {base, q_head.frame[3]};
    endcase
  end

  // Second step: zero and limit check
  always_comb begin
    case (qry_r)
      Q_VOLTAGE: lim_sel = {4'd0, cfg.volt_lim};
      Q_CURRENT: lim_sel = {1'd0, cfg.curr_lim};
      Q_POWER:   lim_sel = {8'd0, cfg.power_lim};
      default:   lim_sel = 24'hFFFFFF;
    endcase
  end
  assign in_range = (val_r != 24'd0) && (val_r <= lim_sel);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_head.is_frame ? B_DEC : B_REQ;
        end
      end
      B_REQ: begin
        if (out_free && cnt_r == 3'd6) begin
          state_nxt = B_IDLE;
        end
      end
      B_DEC: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      volt_r      <= '0;
      curr_r      <= '0;
      power_r     <= '0;
      energy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_REQ || state_r == B_DEC) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == B_DEC && out_free && qry_r != Q_NONE && !bad_r && in_range) begin
        case (qry_r)
          Q_VOLTAGE: volt_r   <= val_r[19:0];
          Q_CURRENT: curr_r   <= val_r[22:0];
          Q_POWER:   power_r  <= val_r[15:0];
          default:   energy_r <= val_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty) begin
      qry_r <= q_head.query;
      cnt_r <= 3'd0;
      val_r <= val_dec;
      bad_r <= bad_dec;
    end
    if (state_r == B_REQ && out_free) begin
      cnt_r        <= cnt_r + 3'd1;
      out_kind_r   <= KIND_REQ;
      out_byte_r   <= req_byte;
      out_last_r   <= cnt_r == 3'd6;
      out_qty_r    <= qry_r;
      out_status_r <= ST_OK;
    end
    if (state_r == B_DEC && out_free) begin
      out_kind_r <= KIND_REPLY;
      out_byte_r <= 8'd0;
      out_last_r <= 1'b0;
      if (qry_r == Q_NONE) begin
        out_qty_r    <= Q_NONE;
        out_status_r <= ST_NO_QUERY;
      end else begin
        out_qty_r    <= qry_r;
        out_status_r <= bad_r ? ST_BAD : (in_range ? ST_OK : ST_RANGE);
      end
    end
  end

  // Readings are live: they change only when a new beat loads the output register
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {energy_r, power_r, curr_r, volt_r, out_status_r, out_qty_r, out_byte_r};

endmodule

>>> sv/energy_meter_poll_and_decode.sv
// Energy meter poll and decode block: configuration registers and module wiring.
// Depends on emp_pkg, emp_front, emp_queue and emp_back.
//
// Usage:
//   in_*  : input stream. in_tuser is the command (0 poll tick, 1 received byte),
//           in_tdata the received byte. A tick, when enabled and no query is
//           pending, produces a 7-byte request; each 7th received byte closes a
//           reply frame and produces one result beat.
//   out_* : result stream. out_tuser is the kind (0 request byte, 1 reply),
//           out_tlast marks the final request byte, out_tdata carries the byte,
//           query, status and the four stored readings.
//   cfg_* : register writes by index, always ready; write only while idle.
// Throughput: an input beat per cycle while the two-entry queue has room. The
// back end takes one queue entry at a time, then sends its request bytes one by
// one or checks and decodes its reply; a stalled receiver holds it in either.
// A tick passes through the queue, the back end state and the output register
// to the first request byte; the seventh byte of a reply takes the same path.
// Reset: registers return to defaults, poll step 1, no query pending, readings 0.
// A stalled receiver holds the output register; the queue then fills and
// in_tready drops, while dropped ticks and frame bytes still flow until full.
module energy_meter_poll_and_decode #(
  parameter int POLL_CYCLE = emp_pkg::POLL_CYCLE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_byte, [10:8] quantity, [12:11] status, [32:13] voltage_tenths,
  // [55:33] current_hundredths, [71:56] power_watts, [95:72] energy_wh
  output logic [95:0] out_tdata,
  output logic        out_tlast,  // last
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import emp_pkg::*;

  emp_cfg_t cfg_r;
  emp_op_t  push_data, head;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enabled: 1'b1, address: ADDR_RST, volt_lim: VOLT_LIM_RST,
                 curr_lim: CURR_LIM_RST, power_lim: POWER_LIM_RST};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLED:   cfg_r.enabled   <= cfg_data[0];
        CFG_ADDRESS:   cfg_r.address   <= cfg_data;
        CFG_VOLT_LIM:  cfg_r.volt_lim  <= cfg_data[19:0];
        CFG_CURR_LIM:  cfg_r.curr_lim  <= cfg_data[22:0];
        CFG_POWER_LIM: cfg_r.power_lim <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  emp_front #(
    .POLL_CYCLE(POLL_CYCLE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .enabled   (cfg_r.enabled),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  emp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  emp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> sim/energy_meter_poll_and_decode_tb.sv
// Self-checking testbench for energy_meter_poll_and_decode: polls, replies and register writes.
// Predicts every result beat in step with the accepted input beats and compares it field by field.
// Depends on emp_pkg and the energy_meter_poll_and_decode RTL.
`timescale 1ns / 1ps

module energy_meter_poll_and_decode_tb;
  import emp_pkg::*;

  localparam int POLL_STEPS = POLL_CYCLE_DEF;
  localparam logic [2:0] CFG_SPARE = 3'd6;  // index with no register behind it

  typedef enum {
    RP_GOOD, RP_ZERO, RP_OVER, RP_RAW, RP_MAX, RP_BAD_HEADER, RP_BAD_SUM
  } reply_shape_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [2:0]  qty;
    logic [1:0]  status;
    logic [19:0] volts;
    logic [22:0] amps;
    logic [15:0] watts;
    logic [23:0] wh;
  } meter_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Register copies
  logic        reg_enabled;
  logic [31:0] reg_address;
  logic [19:0] reg_volt_lim;
  logic [22:0] reg_curr_lim;
  logic [15:0] reg_power_lim;

  // Block state copies
  int unsigned poll_step;
  logic [2:0]  pend_query;
  int unsigned rx_index;
  logic [7:0]  rx_frame [FRAME_BYTES];
  logic [19:0] volts_store;
  logic [22:0] amps_store;
  logic [15:0] watts_store;
  logic [23:0] wh_store;

  meter_beat_t expected_beats [$];
  int          mismatches = 0;
  int          snd_gap_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_left = 0;

  energy_meter_poll_and_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic logic [2:0] query_for_step(int unsigned s);
    if (s == POLL_STEPS) return Q_ENERGY;
    if (s % 4 != 0) return Q_CURRENT;
    return ((s / 4) % 2 == 1) ? Q_VOLTAGE : Q_POWER;
  endfunction

  function automatic void push_beat(logic kind, logic [7:0] tx, logic last,
                                    logic [2:0] qty, logic [1:0] status);
    meter_beat_t b;
    b = '{kind, tx, last, qty, status, volts_store, amps_store, watts_store, wh_store};
    expected_beats.push_back(b);
  endfunction

  // Check header and sum, then decode and store the reading when it is in range
  function automatic logic [1:0] decode_reply(logic [2:0] q, logic [7:0] sum_byte);
    logic [7:0]  sum;
    int unsigned d0, d1, d2, v;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES; i++) sum += rx_frame[i];
    if (rx_frame[0] != RESP_BASE + 8'(q) || sum != sum_byte) return ST_BAD;
    d0 = 32'(rx_frame[1]);
    d1 = 32'(rx_frame[2]);
    d2 = 32'(rx_frame[3]);
    case (q)
      Q_VOLTAGE: begin
        v = (d0 * 256 + d1) * 10 + d2;
        if (v == 0 || v > reg_volt_lim) return ST_RANGE;
        volts_store = 20'(v);
      end
      Q_CURRENT: begin
        v = (d0 * 256 + d1) * 100 + d2;
        if (v == 0 || v > reg_curr_lim) return ST_RANGE;
        amps_store = 23'(v);
      end
      Q_POWER: begin
        v = d0 * 256 + d1;
        if (v == 0 || v > reg_power_lim) return ST_RANGE;
        watts_store = 16'(v);
      end
      default: begin
        v = (d0 << 16) | (d1 << 8) | d2;
        if (v == 0) return ST_RANGE;
        wh_store = 24'(v);
      end
    endcase
    return ST_OK;
  endfunction

  function automatic void predict_meter(logic cmd, logic [7:0] rx);
    logic [7:0] req [7];
    logic [2:0] q;
    logic [1:0] st;
    if (cmd == CMD_TICK) begin
      if (!reg_enabled || pend_query != Q_NONE) return;
      q = query_for_step(poll_step);
      req[0] = REQ_BASE + 8'(q);
      req[1] = reg_address[31:24];
      req[2] = reg_address[23:16];
      req[3] = reg_address[15:8];
      req[4] = reg_address[7:0];
      req[5] = 8'h00;
      req[6] = req[0] + req[1] + req[2] + req[3] + req[4] + req[5];
      pend_query = q;
      poll_step = (poll_step >= POLL_STEPS) ? 1 : poll_step + 1;
      for (int i = 0; i < 7; i++) push_beat(KIND_REQ, req[i], i == 6, q, ST_OK);
    end else if (rx_index < FRAME_BYTES) begin
      rx_frame[rx_index] = rx;
      rx_index++;
    end else begin
      q = pend_query;
      if (q >= Q_NONE) begin
        q = Q_NONE;
        st = ST_NO_QUERY;
      end else begin
        st = decode_reply(q, rx);
      end
      pend_query = Q_NONE;
      rx_index = 0;
      push_beat(KIND_REPLY, 8'h00, 1'b0, q, st);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    meter_beat_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, got kind %0b data %h",
                 $time, out_tuser, out_tdata);
      end else begin
        w = expected_beats.pop_front();
        compare_field("kind", 32'(w.kind), 32'(out_tuser));
        compare_field("tx_byte", 32'(w.tx), 32'(out_tdata[7:0]));
        compare_field("last", 32'(w.last), 32'(out_tlast));
        compare_field("quantity", 32'(w.qty), 32'(out_tdata[10:8]));
        compare_field("status", 32'(w.status), 32'(out_tdata[12:11]));
        compare_field("voltage_tenths", 32'(w.volts), 32'(out_tdata[32:13]));
        compare_field("current_hundredths", 32'(w.amps), 32'(out_tdata[55:33]));
        compare_field("power_watts", 32'(w.watts), 32'(out_tdata[71:56]));
        compare_field("energy_wh", 32'(w.wh), 32'(out_tdata[95:72]));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin snd_gap_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_gap_pct = 57; rcv_stall_pct = 0;  end
      2: begin snd_gap_pct = 0;  rcv_stall_pct = 57; end
      default: begin snd_gap_pct = 8; rcv_stall_pct = 8; end
    endcase
  endtask

  // Send one beat; valid stays high on return so back-to-back beats need no gap
  task automatic send_item(logic cmd, logic [7:0] rx);
    cfg_valid = 1'b0;
    while ($urandom_range(99) < snd_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = rx;
    do @(posedge clk); while (!in_tready);
    predict_meter(cmd, rx);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLED:   reg_enabled   = data[0];
      CFG_ADDRESS:   reg_address   = data;
      CFG_VOLT_LIM:  reg_volt_lim  = data[19:0];
      CFG_CURR_LIM:  reg_curr_lim  = data[22:0];
      CFG_POWER_LIM: reg_power_lim = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop the inputs, let every expected beat drain, then allow for beats still in flight
  task automatic wait_idle();
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned limit_of(logic [2:0] q);
    case (q)
      Q_VOLTAGE: return 32'(reg_volt_lim);
      Q_CURRENT: return 32'(reg_curr_lim);
      Q_POWER:   return 32'(reg_power_lim);
      default:   return 32'h00FF_FFFF;
    endcase
  endfunction

  // Largest reading that reading_bytes can place in the three data bytes
  function automatic int unsigned ceiling_of(logic [2:0] q);
    case (q)
      Q_VOLTAGE: return 655359;
      Q_CURRENT: return 6553599;
      Q_POWER:   return 65535;
      default:   return 32'h00FF_FFFF;
    endcase
  endfunction

  function automatic logic [23:0] reading_bytes(logic [2:0] q, int unsigned v);
    case (q)
      Q_VOLTAGE: return {16'(v / 10), 8'(v % 10)};
      Q_CURRENT: return {16'(v / 100), 8'(v % 100)};
      Q_POWER:   return {16'(v), 8'($urandom)};
      default:   return 24'(v);
    endcase
  endfunction

  function automatic reply_shape_t pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 40) return RP_GOOD;
    if (r < 50) return RP_ZERO;
    if (r < 62) return RP_OVER;
    if (r < 72) return RP_RAW;
    if (r < 78) return RP_MAX;
    if (r < 89) return RP_BAD_HEADER;
    return RP_BAD_SUM;
  endfunction

  // Seven reply bytes for the pending query (a random one when none is pending), realigned to a frame boundary first
  task automatic send_reply(reply_shape_t shape);
    logic [2:0]  q;
    logic [7:0]  hdr, pad_a, pad_b, sum;
    logic [23:0] val;
    int unsigned lim, top, ceil;
    while (rx_index != 0) send_item(CMD_RX, 8'($urandom));
    q = (pend_query == Q_NONE) ? 3'($urandom_range(3)) : pend_query;
    hdr = RESP_BASE + 8'(q);
    lim = limit_of(q);
    ceil = ceiling_of(q);
    top = (lim < ceil) ? lim : ceil;
    val = 24'($urandom);
    case (shape)
      RP_GOOD: if (top != 0) val = reading_bytes(q, $urandom_range(top, 1));
      RP_ZERO: val = reading_bytes(q, 0);
      RP_OVER: if (lim < ceil) val = reading_bytes(q, $urandom_range(ceil, lim + 1));
      RP_MAX:  val = '1;
      RP_BAD_HEADER: do hdr = 8'($urandom); while (hdr == RESP_BASE + 8'(q));
      default: ;
    endcase
    pad_a = 8'($urandom);
    pad_b = 8'($urandom);
    sum = hdr + val[23:16] + val[15:8] + val[7:0] + pad_a + pad_b;
    if (shape == RP_BAD_SUM) sum ^= 8'($urandom_range(255, 1));
    send_item(CMD_RX, hdr);
    send_item(CMD_RX, val[23:16]);
    send_item(CMD_RX, val[15:8]);
    send_item(CMD_RX, val[7:0]);
    send_item(CMD_RX, pad_a);
    send_item(CMD_RX, pad_b);
    send_item(CMD_RX, sum);
  endtask

  task automatic poll_and_reply(reply_shape_t shape);
    if (pend_query != Q_NONE) send_reply(RP_RAW);
    send_item(CMD_TICK, 8'($urandom));
    send_reply(shape);
  endtask

  task automatic send_noise();
    int n;
    if ($urandom_range(1) == 0) begin
      send_item(CMD_TICK, 8'($urandom));
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) send_item(CMD_RX, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reply with nothing pending, an all-ones reply, and a tick dropped while pending
  task automatic test_directed();
    set_idle(0);
    send_reply(RP_GOOD);
    send_item(CMD_TICK, 8'hFF);
    send_reply(RP_MAX);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_reply(RP_GOOD);
    wait_idle();
  endtask

  task automatic test_registers();
    set_idle(3);
    cfg_write(CFG_ENABLED, 32'h0);
    send_item(CMD_TICK, 8'($urandom));
    send_reply(RP_GOOD);
    wait_idle();
    cfg_write(CFG_ENABLED, 32'hFFFF_FFFF);
    cfg_write(CFG_ADDRESS, 32'h0000_0000);
    poll_and_reply(RP_GOOD);
    wait_idle();
    cfg_write(CFG_ADDRESS, 32'hFFFF_FFFF);
    cfg_write(CFG_VOLT_LIM, 32'h0);
    cfg_write(CFG_CURR_LIM, 32'h0);
    cfg_write(CFG_POWER_LIM, 32'h0);
    poll_and_reply(RP_RAW);
    wait_idle();
    // all ones: the upper bits must be masked off
    cfg_write(CFG_VOLT_LIM, 32'hFFFF_FFFF);
    cfg_write(CFG_CURR_LIM, 32'hFFFF_FFFF);
    cfg_write(CFG_POWER_LIM, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE, 32'($urandom));
    cfg_write(CFG_ADDRESS, $urandom);
    poll_and_reply(RP_MAX);
    wait_idle();
    cfg_write(CFG_VOLT_LIM, 655605);
    cfg_write(CFG_CURR_LIM, 6553755);
    cfg_write(CFG_POWER_LIM, 65535);
    poll_and_reply(RP_GOOD);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int r;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(CFG_ADDRESS, $urandom);
      cfg_write(CFG_VOLT_LIM, $urandom_range(655605));
      cfg_write(CFG_CURR_LIM, $urandom_range(6553755));
      cfg_write(CFG_POWER_LIM, $urandom_range(65535));
      cfg_write(CFG_ENABLED, 32'($urandom_range(4) != 0));
      set_idle(ph);
      r = $urandom_range(99);
      if (r < 80) poll_and_reply(pick_shape());
      else if (r < 95) send_noise();
      else send_reply(pick_shape());
      wait_idle();
    end
    cfg_write(CFG_ENABLED, 32'h1);
  endtask

  // Hold the receiver off while polls keep coming, so the block backs up into its input
  task automatic test_backpressure();
    set_idle(0);
    hold_left = 400;
    repeat (3) poll_and_reply(pick_shape());
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ENABLED;
    cfg_data   = '0;
    reg_enabled   = 1'b1;
    reg_address   = ADDR_RST;
    reg_volt_lim  = VOLT_LIM_RST;
    reg_curr_lim  = CURR_LIM_RST;
    reg_power_lim = POWER_LIM_RST;
    poll_step   = 1;
    pend_query  = Q_NONE;
    rx_index    = 0;
    volts_store = '0;
    amps_store  = '0;
    watts_store = '0;
    wh_store    = '0;
    for (int i = 0; i < FRAME_BYTES; i++) rx_frame[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_registers();
    test_random_traffic();
    test_backpressure();

    in_tvalid = 1'b0;
    n = 0;
    while (expected_beats.size() != 0 && n < 100000) begin
      @(negedge clk);
      n++;
    end
    repeat (20) @(negedge clk);
    if (expected_beats.size() != 0) begin
      mismatches += expected_beats.size();
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
    end
    if (mismatches == 0) begin
      $display("PASS energy_meter_poll_and_decode");
    end else begin
      $display("FAIL energy_meter_poll_and_decode");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL energy_meter_poll_and_decode");
    $finish;
  end

endmodule

>>> sim.f
sv/emp_pkg.sv
sv/emp_front.sv
sv/emp_queue.sv
sv/emp_back.sv
sv/energy_meter_poll_and_decode.sv
sim/energy_meter_poll_and_decode_tb.sv
